FILE: rtl/barycentric_weights_2d_macros.svh
// Assertion macros shared by the barycentric weight block.
`ifndef BARYCENTRIC_WEIGHTS_2D_MACROS_SVH
`define BARYCENTRIC_WEIGHTS_2D_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define BCW_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define BCW_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bcw_pkg.sv
// Shared widths, types and constants of the barycentric weight pipeline.
package bcw_pkg;

    // Coordinate and weight formats.
    localparam int COORD_BITS       = 24;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_BITS      = 32;

    // Edge differences, products and sums are exact.
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 1;

    // Scaled numerator width, and one quotient bit per divider stage.
    localparam int NUM_W      = SUM_W + WEIGHT_FRAC_BITS;
    localparam int DIV_STAGES = WEIGHT_BITS;
    localparam int WIDE_W     = WEIGHT_BITS + 2;

    typedef logic signed [COORD_BITS-1:0]  coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic        [SUM_W-1:0]       mag_t;
    typedef logic signed [WEIGHT_BITS-1:0] weight_t;
    typedef logic signed [WIDE_W-1:0]      wide_weight_t;

    localparam weight_t WEIGHT_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam weight_t WEIGHT_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
    localparam wide_weight_t WEIGHT_ONE = WIDE_W'(1) << WEIGHT_FRAC_BITS;

    // One lane of the restoring divider as it moves down the pipeline.
    typedef struct packed {
        mag_t                   rem;
        logic [WEIGHT_BITS-1:0] low;
        logic [WEIGHT_BITS-1:0] quo;
        logic                   neg;
        logic                   ovf;
    } div_lane_t;

endpackage

FILE: rtl/bcw_edge.sv
// Edge differences, cross products and determinant/numerator sums (three stages).
module bcw_edge (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           valid_in,
    input  bcw_pkg::coord_t ref_x,
    input  bcw_pkg::coord_t ref_y,
    input  bcw_pkg::coord_t first_x,
    input  bcw_pkg::coord_t first_y,
    input  bcw_pkg::coord_t second_x,
    input  bcw_pkg::coord_t second_y,
    input  bcw_pkg::coord_t third_x,
    input  bcw_pkg::coord_t third_y,
    output logic           valid_out,
    output bcw_pkg::sum_t  det,
    output bcw_pkg::sum_t  num_first,
    output bcw_pkg::sum_t  num_second
);
    import bcw_pkg::*;

    diff_t e_by_reg, e_cx_reg, e_ay_reg, e_ax_reg, dx_reg, dy_reg;
    prod_t p_det_a_reg, p_det_b_reg, p_n1_a_reg, p_n1_b_reg, p_n2_a_reg, p_n2_b_reg;
    sum_t  det_reg, n1_reg, n2_reg;
    logic  v1_reg, v2_reg, v3_reg;

    // Signed difference of two coordinates, one bit wider.
    function automatic diff_t sub_coord(coord_t a, coord_t b);
        return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    endfunction

    // Sign-extend a product to the sum width.
    function automatic sum_t ext_prod(prod_t p);
        return {p[PROD_W-1], p};
    endfunction

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage one: edge vectors relative to the third vertex.
    always_ff @(posedge aclk) begin
        if (en) begin
            e_by_reg <= sub_coord(second_y, third_y);
            e_cx_reg <= sub_coord(third_x, second_x);
            e_ay_reg <= sub_coord(third_y, first_y);
            e_ax_reg <= sub_coord(first_x, third_x);
            dx_reg   <= sub_coord(ref_x, third_x);
            dy_reg   <= sub_coord(ref_y, third_y);
        end
    end

    // Stage two: six independent products.
    always_ff @(posedge aclk) begin
        if (en) begin
            p_det_a_reg <= e_by_reg * e_ax_reg;
            p_det_b_reg <= e_cx_reg * e_ay_reg;
            p_n1_a_reg  <= e_by_reg * dx_reg;
            p_n1_b_reg  <= e_cx_reg * dy_reg;
            p_n2_a_reg  <= e_ay_reg * dx_reg;
            p_n2_b_reg  <= e_ax_reg * dy_reg;
        end
    end

    // Stage three: determinant and the two weight numerators.
    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg <= ext_prod(p_det_a_reg) - ext_prod(p_det_b_reg);
            n1_reg  <= ext_prod(p_n1_a_reg) + ext_prod(p_n1_b_reg);
            n2_reg  <= ext_prod(p_n2_a_reg) + ext_prod(p_n2_b_reg);
        end
    end

    assign valid_out  = v3_reg;
    assign det        = det_reg;
    assign num_first  = n1_reg;
    assign num_second = n2_reg;

endmodule

FILE: rtl/bcw_div_step.sv
// One restoring-division stage: retires one quotient bit per clock while enabled.
module bcw_div_step (
    input  logic               aclk,
    input  logic               en,
    input  bcw_pkg::div_lane_t lane_in,
    input  bcw_pkg::mag_t      den,
    output bcw_pkg::div_lane_t lane_out
);
    import bcw_pkg::*;

    div_lane_t              lane_reg, lane_next;
    logic [SUM_W:0]         rem_sh;
    logic [SUM_W+1:0]       trial;
    logic                   fits;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
        rem_sh = {lane_in.rem, lane_in.low[WEIGHT_BITS-1]};
        trial  = {1'b0, rem_sh} - {2'b00, den};
        fits   = !trial[SUM_W+1];
        lane_next      = lane_in;
        lane_next.rem  = fits ? trial[SUM_W-1:0] : rem_sh[SUM_W-1:0];
        lane_next.low  = {lane_in.low[WEIGHT_BITS-2:0], 1'b0};
        lane_next.quo  = {lane_in.quo[WEIGHT_BITS-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

FILE: rtl/bcw_div.sv
// Pipelined scaled divider for both weight numerators over the determinant.
module bcw_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               valid_in,
    input  bcw_pkg::sum_t      det,
    input  bcw_pkg::sum_t      num_first,
    input  bcw_pkg::sum_t      num_second,
    output logic               valid_out,
    output logic               degen_out,
    output bcw_pkg::div_lane_t lane_first,
    output bcw_pkg::div_lane_t lane_second
);
    import bcw_pkg::*;

    localparam int NX_W = NUM_W + WEIGHT_BITS;

    mag_t      mag_det_reg, mag1_reg, mag2_reg;
    logic      neg1_reg, neg2_reg, degen4_reg, v4_reg;
    div_lane_t lane1_s5_reg, lane2_s5_reg;
    div_lane_t lane1_chain [0:DIV_STAGES];
    div_lane_t lane2_chain [0:DIV_STAGES];
    mag_t      den_reg     [0:DIV_STAGES-1];
    logic      degen_reg   [0:DIV_STAGES];
    logic      valid_reg   [0:DIV_STAGES];

    // Magnitude of a signed sum.
    function automatic mag_t abs_sum(sum_t s);
        return s[SUM_W-1] ? mag_t'(-s) : mag_t'(s);
    endfunction

    // Scale the numerator and seed the remainder with its bits above the
    // quotient; an overflow flag marks quotients of 2^WEIGHT_BITS or more.
    function automatic div_lane_t seed_lane(mag_t num_mag, mag_t den_mag, logic neg);
        logic [NX_W-1:0]  nx;
        logic [NUM_W-1:0] top;
        div_lane_t        lane;
        nx        = {{WEIGHT_BITS{1'b0}}, num_mag, {WEIGHT_FRAC_BITS{1'b0}}};
        top       = nx[NX_W-1:WEIGHT_BITS];
        lane.rem  = top[SUM_W-1:0];
        lane.low  = nx[WEIGHT_BITS-1:0];
        lane.quo  = '0;
        lane.neg  = neg;
        lane.ovf  = (top >= {{WEIGHT_FRAC_BITS{1'b0}}, den_mag});
        return lane;
    endfunction

    // Valid bits for the two setup stages and the divider stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            for (int i = 0; i <= DIV_STAGES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v4_reg       <= valid_in;
            valid_reg[0] <= v4_reg;
            for (int i = 0; i < DIV_STAGES; i++) begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end
    end

    // Setup stage one: magnitudes, quotient signs and the degenerate test.
    always_ff @(posedge aclk) begin
        if (en) begin
            mag_det_reg <= abs_sum(det);
            mag1_reg    <= abs_sum(num_first);
            mag2_reg    <= abs_sum(num_second);
            neg1_reg    <= num_first[SUM_W-1] ^ det[SUM_W-1];
            neg2_reg    <= num_second[SUM_W-1] ^ det[SUM_W-1];
            degen4_reg  <= (det == '0);
        end
    end

    // Setup stage two: overflow check and remainder seed.
    always_ff @(posedge aclk) begin
        if (en) begin
            lane1_s5_reg <= seed_lane(mag1_reg, mag_det_reg, neg1_reg);
            lane2_s5_reg <= seed_lane(mag2_reg, mag_det_reg, neg2_reg);
        end
    end

    // Divisor and degenerate flag enter with the seeded lanes and follow
    // them down the divider.
    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0]   <= mag_det_reg;
            degen_reg[0] <= degen4_reg;
            for (int i = 0; i < DIV_STAGES - 1; i++) begin
                den_reg[i+1] <= den_reg[i];
            end
            for (int i = 0; i < DIV_STAGES; i++) begin
                degen_reg[i+1] <= degen_reg[i];
            end
        end
    end

    assign lane1_chain[0] = lane1_s5_reg;
    assign lane2_chain[0] = lane2_s5_reg;

    // One quotient bit per stage, both lanes side by side.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
        bcw_div_step u_step_first (
            .aclk     (aclk),
            .en       (en),
            .lane_in  (lane1_chain[k]),
            .den      (den_reg[k]),
            .lane_out (lane1_chain[k+1])
        );
        bcw_div_step u_step_second (
            .aclk     (aclk),
            .en       (en),
            .lane_in  (lane2_chain[k]),
            .den      (den_reg[k]),
            .lane_out (lane2_chain[k+1])
        );
    end

    assign valid_out   = valid_reg[DIV_STAGES];
    assign degen_out   = degen_reg[DIV_STAGES];
    assign lane_first  = lane1_chain[DIV_STAGES];
    assign lane_second = lane2_chain[DIV_STAGES];

endmodule

FILE: rtl/bcw_out.sv
// Quotient saturation, third weight and the output register (two stages).
module bcw_out (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               valid_in,
    input  logic               degen_in,
    input  bcw_pkg::div_lane_t lane_first,
    input  bcw_pkg::div_lane_t lane_second,
    output logic               valid_out,
    output bcw_pkg::weight_t   weight_first,
    output bcw_pkg::weight_t   weight_second,
    output bcw_pkg::weight_t   weight_third,
    output logic               degenerate
);
    import bcw_pkg::*;

    weight_t      w1a_reg, w2a_reg;
    logic         degen_a_reg, va_reg;
    weight_t      w1_reg, w2_reg, w3_reg;
    logic         degen_reg, vb_reg;
    wide_weight_t w3_wide;
    weight_t      w3_sat;

    // Signed, saturated weight from an unsigned quotient and its sign.
    function automatic weight_t sat_quo(div_lane_t lane);
        weight_t res;
        if (lane.ovf) begin
            res = lane.neg ? WEIGHT_MIN : WEIGHT_MAX;
        end else if (lane.neg) begin
            res = (lane.quo[WEIGHT_BITS-1] && (|lane.quo[WEIGHT_BITS-2:0])) ?
                  WEIGHT_MIN : weight_t'(-lane.quo);
        end else begin
            res = lane.quo[WEIGHT_BITS-1] ? WEIGHT_MAX : weight_t'(lane.quo);
        end
        return res;
    endfunction

    // Valid bits for both stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= valid_in;
            vb_reg <= va_reg;
        end
    end

    // Stage one: saturate the two quotients; a degenerate triangle gives zeros.
    always_ff @(posedge aclk) begin
        if (en) begin
            w1a_reg     <= degen_in ? '0 : sat_quo(lane_first);
            w2a_reg     <= degen_in ? '0 : sat_quo(lane_second);
            degen_a_reg <= degen_in;
        end
    end

    // Third weight is one minus the other two, clamped to the weight range.
    always_comb begin
        w3_wide = WEIGHT_ONE - {{2{w1a_reg[WEIGHT_BITS-1]}}, w1a_reg}
                             - {{2{w2a_reg[WEIGHT_BITS-1]}}, w2a_reg};
        if (!w3_wide[WIDE_W-1] && (|w3_wide[WIDE_W-2:WEIGHT_BITS-1])) begin
            w3_sat = WEIGHT_MAX;
        end else if (w3_wide[WIDE_W-1] && !(&w3_wide[WIDE_W-2:WEIGHT_BITS-1])) begin
            w3_sat = WEIGHT_MIN;
        end else begin
            w3_sat = w3_wide[WEIGHT_BITS-1:0];
        end
    end

    // Stage two: the output register.
    always_ff @(posedge aclk) begin
        if (en) begin
            w1_reg    <= w1a_reg;
            w2_reg    <= w2a_reg;
            w3_reg    <= degen_a_reg ? '0 : w3_sat;
            degen_reg <= degen_a_reg;
        end
    end

    assign valid_out     = vb_reg;
    assign weight_first  = w1_reg;
    assign weight_second = w2_reg;
    assign weight_third  = w3_reg;
    assign degenerate    = degen_reg;

endmodule

FILE: rtl/barycentric_weights_2d.sv
// Barycentric weights of a point in a 2-D triangle: one word per clock while
// the output is not stalled. Each word passes three stages of edge products and
// sums and two setup stages, then the divider, which retires one quotient bit per
// stage for each of the two weights (32 stages), followed by two stages of
// saturation and the output register.
// The pipeline moves whenever the output register is empty or being read; a
// one-word input buffer lets the block take a word while a result waits.
// Weights are signed Q15.16, truncated toward zero and saturated; a zero
// determinant raises the degenerate flag and returns all weights as zero.

`include "barycentric_weights_2d_macros.svh"

module barycentric_weights_2d (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bcw_pkg::coord_t   s_ref_x,
    input  bcw_pkg::coord_t   s_ref_y,
    input  bcw_pkg::coord_t   s_first_x,
    input  bcw_pkg::coord_t   s_first_y,
    input  bcw_pkg::coord_t   s_second_x,
    input  bcw_pkg::coord_t   s_second_y,
    input  bcw_pkg::coord_t   s_third_x,
    input  bcw_pkg::coord_t   s_third_y,
    output logic              m_valid,
    input  logic              m_ready,
    output bcw_pkg::weight_t  m_weight_first,
    output bcw_pkg::weight_t  m_weight_second,
    output bcw_pkg::weight_t  m_weight_third,
    output logic              m_degenerate
);
    import bcw_pkg::*;

    logic         advance;
    logic         s_take;
    logic         skid_valid_reg, skid_valid_next;
    coord_t       skid_rx_reg, skid_ry_reg, skid_ax_reg, skid_ay_reg;
    coord_t       skid_bx_reg, skid_by_reg, skid_cx_reg, skid_cy_reg;
    logic         pipe_valid;
    coord_t       p_rx, p_ry, p_ax, p_ay, p_bx, p_by, p_cx, p_cy;
    logic         edge_valid, div_valid, div_degen;
    sum_t         det, num_first, num_second;
    div_lane_t    lane_first, lane_second;
    wide_weight_t weight_sum;

    // The whole pipeline steps when the output register can take a word.
    assign advance = !m_valid || m_ready;
    assign s_ready = !skid_valid_reg;
    assign s_take  = s_valid && s_ready;

    // A word that arrives during a stall parks in the input buffer.
    always_comb begin
        skid_valid_next = skid_valid_reg;
        if (advance) begin
            skid_valid_next = 1'b0;
        end else if (s_take) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            skid_rx_reg <= s_ref_x;
            skid_ry_reg <= s_ref_y;
            skid_ax_reg <= s_first_x;
            skid_ay_reg <= s_first_y;
            skid_bx_reg <= s_second_x;
            skid_by_reg <= s_second_y;
            skid_cx_reg <= s_third_x;
            skid_cy_reg <= s_third_y;
        end
    end

    // Pipeline input comes from the buffer first, else straight from the port.
    assign pipe_valid = skid_valid_reg || s_take;
    assign p_rx = skid_valid_reg ? skid_rx_reg : s_ref_x;
    assign p_ry = skid_valid_reg ? skid_ry_reg : s_ref_y;
    assign p_ax = skid_valid_reg ? skid_ax_reg : s_first_x;
    assign p_ay = skid_valid_reg ? skid_ay_reg : s_first_y;
    assign p_bx = skid_valid_reg ? skid_bx_reg : s_second_x;
    assign p_by = skid_valid_reg ? skid_by_reg : s_second_y;
    assign p_cx = skid_valid_reg ? skid_cx_reg : s_third_x;
    assign p_cy = skid_valid_reg ? skid_cy_reg : s_third_y;

    bcw_edge u_edge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .valid_in   (pipe_valid),
        .ref_x      (p_rx),
        .ref_y      (p_ry),
        .first_x    (p_ax),
        .first_y    (p_ay),
        .second_x   (p_bx),
        .second_y   (p_by),
        .third_x    (p_cx),
        .third_y    (p_cy),
        .valid_out  (edge_valid),
        .det        (det),
        .num_first  (num_first),
        .num_second (num_second)
    );

    bcw_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .valid_in    (edge_valid),
        .det         (det),
        .num_first   (num_first),
        .num_second  (num_second),
        .valid_out   (div_valid),
        .degen_out   (div_degen),
        .lane_first  (lane_first),
        .lane_second (lane_second)
    );

    bcw_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (advance),
        .valid_in      (div_valid),
        .degen_in      (div_degen),
        .lane_first    (lane_first),
        .lane_second   (lane_second),
        .valid_out     (m_valid),
        .weight_first  (m_weight_first),
        .weight_second (m_weight_second),
        .weight_third  (m_weight_third),
        .degenerate    (m_degenerate)
    );

    // Sum of the three weights, used to check the third weight.
    assign weight_sum = {{2{m_weight_first[WEIGHT_BITS-1]}}, m_weight_first}
                      + {{2{m_weight_second[WEIGHT_BITS-1]}}, m_weight_second}
                      + {{2{m_weight_third[WEIGHT_BITS-1]}}, m_weight_third};

    // A degenerate result carries zero weights.
    `BCW_ASSERT_ALWAYS(a_degen_zero, !(m_valid && m_degenerate) || (m_weight_first == '0 && m_weight_second == '0 && m_weight_third == '0), "degenerate result with nonzero weights")

    // Unless clamped, the three weights add up to exactly one.
    `BCW_ASSERT_ALWAYS(a_weight_sum, !(m_valid && !m_degenerate) || weight_sum == WEIGHT_ONE || m_weight_third == WEIGHT_MAX || m_weight_third == WEIGHT_MIN, "weights do not sum to one")

    // A word taken during a stall must land in the input buffer.
    `BCW_ASSERT_NEXT(a_skid_load, s_take && !advance, skid_valid_reg, "stalled input word was dropped")

    // A parked word stays parked while the output is still blocked.
    `BCW_ASSERT_NEXT(a_skid_hold, skid_valid_reg && !advance, skid_valid_reg, "parked input word lost during stall")

endmodule
